@@ hdl/pf2d_pkg.sv @@
package pf2d_pkg;

	// field and register widths
	localparam int SAMPLE_W   = 16;
	localparam int ROW_W      = 12;
	localparam int ROWS_W     = 13;
	localparam int CNT_W      = 7;   // column / channel counters
	localparam int OCOL_W     = 6;
	localparam int OCH_W      = 6;
	localparam int WIN_W      = 3;
	localparam int STEP_W     = 3;
	localparam int SLOT_W     = 3;   // row slot in the line store, up to 8 rows
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int WSQ_W      = 2 * WIN_W;
	localparam int SUM_W      = SAMPLE_W + WSQ_W;
	localparam int ROW_LIMIT  = 4096;

	// defaults for the top level parameters
	localparam int MAX_COLS_DEF     = 64;
	localparam int MAX_CHANNELS_DEF = 64;
	localparam int MAX_WINDOW_DEF   = 4;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// register reset values
	localparam logic [ROWS_W-1:0] RST_IN_ROWS      = 13'd1;
	localparam logic [CNT_W-1:0]  RST_IN_COLS      = 7'd1;
	localparam logic [CNT_W-1:0]  RST_NUM_CHANNELS = 7'd1;
	localparam logic [WIN_W-1:0]  RST_WINDOW_SIZE  = 3'd2;
	localparam logic [STEP_W-1:0] RST_STEP_SIZE    = 3'd2;

	localparam logic MODE_MAX = 1'b0;
	localparam logic MODE_AVG = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_ROWS      = 3'd0,
		REG_IN_COLS      = 3'd1,
		REG_NUM_CHANNELS = 3'd2,
		REG_WINDOW_SIZE  = 3'd3,
		REG_STEP_SIZE    = 3'd4,
		REG_POOL_MODE    = 3'd5
	} cfg_reg_t;

	// clamped configuration as seen by the datapath
	typedef struct packed {
		logic [ROWS_W-1:0] rows;
		logic [CNT_W-1:0]  cols;
		logic [CNT_W-1:0]  chans;
		logic [WIN_W-1:0]  win;
		logic [STEP_W-1:0] step;
		logic              mode;
	} cfg_t;

	// one classified request, front to back
	typedef struct packed {
		logic                       store_en;
		logic [SLOT_W-1:0]          slot;
		logic [CNT_W-1:0]           col;
		logic [CNT_W-1:0]           chan;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       has_res;
		logic [ROW_W-1:0]           oy;
		logic [OCOL_W-1:0]          ox;
		logic                       last;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_DRAIN,
		B_FIN,
		B_DIV
	} back_state_t;

endpackage

@@ hdl/pf2d_if.sv @@
interface pf2d_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pf2d_pkg::SAMPLE_W-1:0] sample;
	logic                                 frame_start;

	modport source(output valid, output sample, output frame_start, input ready);
	modport sink(input valid, input sample, input frame_start, output ready);
endinterface

interface pf2d_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pf2d_pkg::SAMPLE_W-1:0] pooled;
	logic [pf2d_pkg::ROW_W-1:0]           out_row;
	logic [pf2d_pkg::OCOL_W-1:0]          out_col;
	logic [pf2d_pkg::OCH_W-1:0]           out_channel;
	logic                                 last;

	modport source(output valid, output pooled, output out_row, output out_col,
		output out_channel, output last, input ready);
	modport sink(input valid, input pooled, input out_row, input out_col,
		input out_channel, input last, output ready);
endinterface

@@ hdl/pf2d_ram.sv @@
module pf2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/pf2d_front.sv @@
module pf2d_front #(
	parameter int MAX_COLS     = pf2d_pkg::MAX_COLS_DEF,
	parameter int MAX_CHANNELS = pf2d_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_WINDOW   = pf2d_pkg::MAX_WINDOW_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pf2d_pkg::cfg_t  cfg,
	pf2d_in_if.sink         samples,
	output logic            push,
	output pf2d_pkg::job_t  job,
	input  logic            full
);

	localparam int NLANE = 4;  // row offset, column offset, last row, last column
	localparam int ROW_W = pf2d_pkg::ROW_W;
	localparam int CNT_W = pf2d_pkg::CNT_W;
	localparam int SLOT_W = pf2d_pkg::SLOT_W;
	localparam int STEP_W = pf2d_pkg::STEP_W;
	localparam logic [3:0] ITER_LAST = 4'(ROW_W - 1);

	pf2d_pkg::front_state_t state_q, state_d;

	logic [ROW_W-1:0]  row_q;
	logic [CNT_W-1:0]  col_q, chan_q;
	logic [SLOT_W-1:0] slot_q;
	logic              cand_q;
	logic [3:0]        iter_q;
	pf2d_pkg::job_t    job_q;
	logic [ROW_W-1:0]  dvd_q [NLANE];
	logic [STEP_W-1:0] rem_q [NLANE];

	logic              accept;
	logic [ROW_W-1:0]  r;
	logic [CNT_W-1:0]  c, ch;
	logic [SLOT_W-1:0] s;
	logic              cand;
	logic [ROW_W-1:0]  lane_init [NLANE];
	logic [ROW_W-1:0]  dvd_n [NLANE];
	logic [STEP_W-1:0] rem_n [NLANE];
	logic [STEP_W:0]   rem_sh [NLANE];
	logic              ge [NLANE];
	logic [CNT_W:0]    ch_inc, c_inc;
	logic [ROW_W:0]    r_inc;
	logic [ROW_W-1:0]  row_n;
	logic [CNT_W-1:0]  col_n, chan_n;
	logic [SLOT_W-1:0] slot_n;

	assign accept = samples.valid && samples.ready;

	// position of this sample and the next one
	always_comb begin
		r  = samples.frame_start ? '0 : row_q;
		c  = samples.frame_start ? '0 : col_q;
		ch = samples.frame_start ? '0 : chan_q;
		s  = samples.frame_start ? '0 : slot_q;

		cand = ({1'b0, r} < cfg.rows) && (c < cfg.cols) && (ch < cfg.chans)
			&& (({1'b0, r} + 13'd1) >= 13'(cfg.win))
			&& ((8'(c) + 8'd1) >= 8'(cfg.win));

		lane_init[0] = ROW_W'({1'b0, r} + 13'd1 - 13'(cfg.win));
		lane_init[1] = ROW_W'(c) + 12'd1 - ROW_W'(cfg.win);
		lane_init[2] = ROW_W'(cfg.rows - 13'(cfg.win));
		lane_init[3] = ROW_W'(cfg.cols) - ROW_W'(cfg.win);

		ch_inc = {1'b0, ch} + 8'd1;
		c_inc  = {1'b0, c} + 8'd1;
		r_inc  = {1'b0, r} + 13'd1;
		row_n  = r;
		col_n  = c;
		chan_n = CNT_W'(ch_inc);
		slot_n = s;
		if (ch_inc >= {1'b0, cfg.chans}) begin
			chan_n = '0;
			col_n  = CNT_W'(c_inc);
			if (c_inc >= {1'b0, cfg.cols}) begin
				col_n = '0;
				if (r_inc >= cfg.rows) begin
					row_n  = '0;
					slot_n = '0;
				end else begin
					row_n  = ROW_W'(r_inc);
					slot_n = (s == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s + 3'd1;
				end
			end
		end
	end

	// one restoring division step per lane, all by the stride
	always_comb begin
		for (int i = 0; i < NLANE; i++) begin
			rem_sh[i] = {rem_q[i], dvd_q[i][ROW_W-1]};
			ge[i]     = rem_sh[i] >= {1'b0, cfg.step};
			rem_n[i]  = ge[i] ? STEP_W'(rem_sh[i] - {1'b0, cfg.step}) : rem_sh[i][STEP_W-1:0];
			dvd_n[i]  = {dvd_q[i][ROW_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pf2d_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		push          = 1'b0;
		unique case (state_q)
			pf2d_pkg::F_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_d = cand ? pf2d_pkg::F_DIV : pf2d_pkg::F_PUSH;
				end
			end
			pf2d_pkg::F_DIV: begin
				if (iter_q == ITER_LAST) begin
					state_d = pf2d_pkg::F_PUSH;
				end
			end
			pf2d_pkg::F_PUSH: begin
				push = !full;
				if (!full) begin
					state_d = pf2d_pkg::F_IDLE;
				end
			end
			default: state_d = pf2d_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		job         = job_q;
		job.has_res = cand_q && (rem_q[0] == '0) && (rem_q[1] == '0);
		job.oy      = dvd_q[0];
		job.ox      = dvd_q[1][pf2d_pkg::OCOL_W-1:0];
		job.last    = (dvd_q[0] == dvd_q[2]) && (dvd_q[1] == dvd_q[3])
			&& (job_q.chan == cfg.chans - 7'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			chan_q <= '0;
			slot_q <= '0;
			cand_q <= 1'b0;
			iter_q <= '0;
		end else if (accept) begin
			row_q  <= row_n;
			col_q  <= col_n;
			chan_q <= chan_n;
			slot_q <= slot_n;
			cand_q <= cand;
			iter_q <= '0;
		end else if (state_q == pf2d_pkg::F_DIV) begin
			iter_q <= iter_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_q.store_en <= (int'(c) < MAX_COLS) && (int'(ch) < MAX_CHANNELS);
			job_q.slot     <= s;
			job_q.col      <= c;
			job_q.chan     <= ch;
			job_q.sample   <= samples.sample;
			job_q.has_res  <= 1'b0;
			job_q.oy       <= '0;
			job_q.ox       <= '0;
			job_q.last     <= 1'b0;
			for (int i = 0; i < NLANE; i++) begin
				dvd_q[i] <= lane_init[i];
				rem_q[i] <= '0;
			end
		end else if (state_q == pf2d_pkg::F_DIV) begin
			for (int i = 0; i < NLANE; i++) begin
				dvd_q[i] <= dvd_n[i];
				rem_q[i] <= rem_n[i];
			end
		end
	end

endmodule

@@ hdl/pf2d_queue.sv @@
module pf2d_queue #(
	parameter int DEPTH = pf2d_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pf2d_pkg::job_t job_in,
	output logic           full,
	input  logic           pop,
	output pf2d_pkg::job_t job_out,
	output logic           empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pf2d_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0]  rd_q, wr_q;
	logic [CW-1:0]  cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign job_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("request pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("request popped from an empty queue");

endmodule

@@ hdl/pf2d_back.sv @@
module pf2d_back #(
	parameter int MAX_COLS     = pf2d_pkg::MAX_COLS_DEF,
	parameter int MAX_CHANNELS = pf2d_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_WINDOW   = pf2d_pkg::MAX_WINDOW_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pf2d_pkg::cfg_t cfg,
	input  pf2d_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	pf2d_out_if.source     results
);

	localparam int SAMPLE_W = pf2d_pkg::SAMPLE_W;
	localparam int SUM_W    = pf2d_pkg::SUM_W;
	localparam int WSQ_W    = pf2d_pkg::WSQ_W;
	localparam int WIN_W    = pf2d_pkg::WIN_W;
	localparam int SLOT_W   = pf2d_pkg::SLOT_W;
	localparam int CNT_W    = pf2d_pkg::CNT_W;
	localparam int PLANE    = MAX_COLS * MAX_CHANNELS;
	localparam int DEPTH    = MAX_WINDOW * PLANE;
	localparam int AW       = $clog2(DEPTH);
	localparam int IW       = $clog2(SUM_W);
	localparam logic [IW-1:0] ITER_LAST = IW'(SUM_W - 1);

	function automatic logic [AW-1:0] store_addr(logic [SLOT_W-1:0] s,
		logic [CNT_W-1:0] c, logic [CNT_W-1:0] ch);
		return AW'(s) * AW'(PLANE) + AW'(c) * AW'(MAX_CHANNELS) + AW'(ch);
	endfunction

	pf2d_pkg::back_state_t state_q, state_d;

	pf2d_pkg::job_t           job_q;
	logic [SLOT_W-1:0]        rslot_q;
	logic [CNT_W-1:0]         col_q;
	logic [WIN_W-1:0]         dx_q, dy_q;
	logic                     rd_valid_q;
	logic                     first_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]         dvd_q;
	logic [WSQ_W-1:0]         rem_q;
	logic [IW-1:0]            iter_q;
	logic                     neg_q;
	logic                     out_valid_q;
	logic signed [SAMPLE_W-1:0] pooled_q;
	pf2d_pkg::job_t           out_job_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_addr;
	logic [SAMPLE_W-1:0]      ram_rdata;
	logic signed [SAMPLE_W-1:0] rd_data;
	logic                     last_tap;
	logic                     load_out;
	logic signed [SAMPLE_W-1:0] pooled_d;
	logic [WSQ_W-1:0]         wsq;
	logic [WSQ_W:0]           rem_sh;
	logic                     ge;
	logic [WSQ_W-1:0]         rem_n;
	logic [SUM_W-1:0]         dvd_n;
	logic [SAMPLE_W-1:0]      quot;

	assign rd_data  = $signed(ram_rdata);
	assign last_tap = (dx_q == cfg.win - 3'd1) && (dy_q == cfg.win - 3'd1);
	assign wsq      = WSQ_W'(cfg.win) * WSQ_W'(cfg.win);

	// restoring divide of the window sum magnitude by window_size squared
	always_comb begin
		rem_sh = {rem_q, dvd_q[SUM_W-1]};
		ge     = rem_sh >= {1'b0, wsq};
		rem_n  = ge ? WSQ_W'(rem_sh - {1'b0, wsq}) : rem_sh[WSQ_W-1:0];
		dvd_n  = {dvd_q[SUM_W-2:0], ge};
		quot   = dvd_n[SAMPLE_W-1:0];
	end

	pf2d_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(head.sample),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pf2d_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		ram_we   = 1'b0;
		ram_addr = store_addr(rslot_q, col_q, job_q.chan);
		load_out = 1'b0;
		pooled_d = acc_q[SAMPLE_W-1:0];
		unique case (state_q)
			pf2d_pkg::B_IDLE: begin
				ram_addr = store_addr(head.slot, head.col, head.chan);
				pop = !empty && (!head.has_res || !out_valid_q || results.ready);
				ram_we = pop && head.store_en;
				if (pop && head.has_res) begin
					state_d = pf2d_pkg::B_READ;
				end
			end
			pf2d_pkg::B_READ: begin
				if (last_tap) begin
					state_d = pf2d_pkg::B_DRAIN;
				end
			end
			pf2d_pkg::B_DRAIN: begin
				state_d = pf2d_pkg::B_FIN;
			end
			pf2d_pkg::B_FIN: begin
				if (cfg.mode == pf2d_pkg::MODE_MAX) begin
					load_out = 1'b1;
					state_d  = pf2d_pkg::B_IDLE;
				end else begin
					state_d = pf2d_pkg::B_DIV;
				end
			end
			pf2d_pkg::B_DIV: begin
				pooled_d = neg_q ? -$signed(quot) : $signed(quot);
				if (iter_q == ITER_LAST) begin
					load_out = 1'b1;
					state_d  = pf2d_pkg::B_IDLE;
				end
			end
			default: state_d = pf2d_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= (state_q == pf2d_pkg::B_READ);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.has_res) begin
			job_q   <= head;
			rslot_q <= head.slot;
			col_q   <= head.col;
			dx_q    <= '0;
			dy_q    <= '0;
			first_q <= 1'b1;
			acc_q   <= '0;
		end else if (state_q == pf2d_pkg::B_READ) begin
			if (dx_q == cfg.win - 3'd1) begin
				dx_q    <= '0;
				dy_q    <= dy_q + 3'd1;
				col_q   <= job_q.col;
				rslot_q <= (rslot_q == '0) ? SLOT_W'(MAX_WINDOW - 1) : rslot_q - 3'd1;
			end else begin
				dx_q  <= dx_q + 3'd1;
				col_q <= col_q - 7'd1;
			end
		end
		if (rd_valid_q) begin
			first_q <= 1'b0;
			if (cfg.mode == pf2d_pkg::MODE_AVG) begin
				acc_q <= acc_q + SUM_W'(rd_data);
			end else if (first_q || (rd_data > $signed(acc_q[SAMPLE_W-1:0]))) begin
				acc_q <= SUM_W'(rd_data);
			end
		end
		if (state_q == pf2d_pkg::B_FIN) begin
			neg_q  <= acc_q[SUM_W-1];
			dvd_q  <= acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
			rem_q  <= '0;
			iter_q <= '0;
		end else if (state_q == pf2d_pkg::B_DIV) begin
			dvd_q  <= dvd_n;
			rem_q  <= rem_n;
			iter_q <= iter_q + IW'(1);
		end
		if (load_out) begin
			pooled_q  <= pooled_d;
			out_job_q <= job_q;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.pooled      = pooled_q;
	assign results.out_row     = out_job_q.oy;
	assign results.out_col     = out_job_q.ox;
	assign results.out_channel = out_job_q.chan[pf2d_pkg::OCH_W-1:0];
	assign results.last        = out_job_q.last;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid_q || $past(results.ready) || !$past(out_valid_q)))
		else $error("result register overwritten before it was taken");
	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pf2d_pkg::B_READ) |-> (dx_q < cfg.win) && (dy_q < cfg.win))
		else $error("window tap counter out of range");

endmodule

@@ hdl/pooling_2d_forward_core.sv @@
// 2-D max / average pooling over a streamed feature map. Samples (signed Q8.8)
// arrive channel fastest, then column, then row; frame_start forces a sample to
// row 0, column 0, channel 0, and the position wraps by itself at frame end. Each
// sample is written into a line store holding the last MAX_WINDOW rows of every
// column and channel. A sample that closes a window's bottom-right corner yields
// one result: the maximum of the window_size squared samples, or their sum
// divided by window_size squared and truncated toward zero. The front takes a
// request, runs a four-lane stride divider when the position can close a
// window, and then hands it to a four-deep queue; it takes no new sample until
// the queue has taken that request. The back writes the store, then for a
// result reads the window_size squared samples through the one store port,
// passes a drain and a finish step, and in average mode runs a restoring
// divider; it pops no new request until the result is done. The front's divider,
// the single store port and the back's read loop set the sustained rate.
// No clearing pass after reset.
module pooling_2d_forward_core #(
	parameter int MAX_COLS     = pf2d_pkg::MAX_COLS_DEF,
	parameter int MAX_CHANNELS = pf2d_pkg::MAX_CHANNELS_DEF,
	parameter int MAX_WINDOW   = pf2d_pkg::MAX_WINDOW_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	pf2d_in_if.sink                            samples,
	pf2d_out_if.source                         results,
	input  logic                               cfg_we,
	input  logic [pf2d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pf2d_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// raw register values, as written
	logic [pf2d_pkg::ROWS_W-1:0] in_rows_q;
	logic [pf2d_pkg::CNT_W-1:0]  in_cols_q;
	logic [pf2d_pkg::CNT_W-1:0]  num_channels_q;
	logic [pf2d_pkg::WIN_W-1:0]  window_size_q;
	logic [pf2d_pkg::STEP_W-1:0] step_size_q;
	logic                        pool_mode_q;

	pf2d_pkg::cfg_t cfg;
	logic           q_push, q_full, q_pop, q_empty;
	pf2d_pkg::job_t q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_rows_q      <= pf2d_pkg::RST_IN_ROWS;
			in_cols_q      <= pf2d_pkg::RST_IN_COLS;
			num_channels_q <= pf2d_pkg::RST_NUM_CHANNELS;
			window_size_q  <= pf2d_pkg::RST_WINDOW_SIZE;
			step_size_q    <= pf2d_pkg::RST_STEP_SIZE;
			pool_mode_q    <= pf2d_pkg::MODE_MAX;
		end else if (cfg_we) begin
			unique case (pf2d_pkg::cfg_reg_t'(cfg_index))
				pf2d_pkg::REG_IN_ROWS:      in_rows_q      <= cfg_data;
				pf2d_pkg::REG_IN_COLS:      in_cols_q      <= cfg_data[pf2d_pkg::CNT_W-1:0];
				pf2d_pkg::REG_NUM_CHANNELS: num_channels_q <= cfg_data[pf2d_pkg::CNT_W-1:0];
				pf2d_pkg::REG_WINDOW_SIZE:  window_size_q  <= cfg_data[pf2d_pkg::WIN_W-1:0];
				pf2d_pkg::REG_STEP_SIZE:    step_size_q    <= cfg_data[pf2d_pkg::STEP_W-1:0];
				pf2d_pkg::REG_POOL_MODE:    pool_mode_q    <= cfg_data[0];
				default: ;  // unknown index: write dropped
			endcase
		end
	end

	// clamp to the legal ranges; zero sizes act as one
	always_comb begin
		if (in_rows_q == '0) begin
			cfg.rows = 13'd1;
		end else if (int'(in_rows_q) > pf2d_pkg::ROW_LIMIT) begin
			cfg.rows = 13'(pf2d_pkg::ROW_LIMIT);
		end else begin
			cfg.rows = in_rows_q;
		end

		if (in_cols_q == '0) begin
			cfg.cols = 7'd1;
		end else if (int'(in_cols_q) > MAX_COLS) begin
			cfg.cols = 7'(MAX_COLS);
		end else begin
			cfg.cols = in_cols_q;
		end

		if (num_channels_q == '0) begin
			cfg.chans = 7'd1;
		end else if (int'(num_channels_q) > MAX_CHANNELS) begin
			cfg.chans = 7'(MAX_CHANNELS);
		end else begin
			cfg.chans = num_channels_q;
		end

		if (window_size_q == '0) begin
			cfg.win = 3'd1;
		end else if (int'(window_size_q) > MAX_WINDOW) begin
			cfg.win = 3'(MAX_WINDOW);
		end else begin
			cfg.win = window_size_q;
		end

		cfg.step = (step_size_q == '0) ? 3'd1 : step_size_q;
		cfg.mode = pool_mode_q;
	end

	// front: position tracking and window classification
	pf2d_front #(
		.MAX_COLS    (MAX_COLS),
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.samples(samples),
		.push   (q_push),
		.job    (q_in),
		.full   (q_full)
	);

	// short queue of classified requests; store writes stay in order with reads
	pf2d_queue #(
		.DEPTH(pf2d_pkg::QUEUE_DEPTH_DEF)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.job_in (q_in),
		.full   (q_full),
		.pop    (q_pop),
		.job_out(q_out),
		.empty  (q_empty)
	);

	// back: line store, window reduction, result register
	pf2d_back #(
		.MAX_COLS    (MAX_COLS),
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_WINDOW  (MAX_WINDOW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (q_out),
		.empty  (q_empty),
		.pop    (q_pop),
		.results(results)
	);

	a_cfg_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.rows != '0) && (cfg.cols != '0) && (cfg.chans != '0) && (cfg.win != '0)
		&& (cfg.step != '0))
		else $error("clamped configuration holds a zero size");

endmodule
